/* rtl/e2o_pkg.sv */
`default_nettype none
package e2o_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int SCALE_WIDTH     = 32;
    localparam int MS_WIDTH        = 16;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // Q15.16 rounding points of the three travel magnitudes
    localparam int LINEAR_SHIFT  = 17;
    localparam int HEADING_SHIFT = 40;
    localparam int STASIS_SHIFT  = 16;

    // speed divider: one quotient bit above the output range, DIV_STEP bits a stage
    localparam int QUOT_WIDTH    = OUT_WIDTH + 1;
    localparam int NUM_WIDTH     = QUOT_WIDTH + MS_WIDTH + 1;
    localparam int DIV_STEP      = 4;
    localparam int DIV_STAGES    = (QUOT_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int CHAN_LATENCY  = DIV_STAGES + 3;
    localparam int FRONT_LATENCY = 5;

    localparam logic [OUT_WIDTH-1:0] SAT_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] SAT_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LEFT_SCALE         = 2'd0,
        REG_RIGHT_SCALE        = 2'd1,
        REG_STASIS_SCALE       = 2'd2,
        REG_INVERSE_WHEEL_BASE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] left_ticks;
        logic signed [COUNT_WIDTH-1:0] right_ticks;
        logic signed [COUNT_WIDTH-1:0] stasis_ticks;
        logic        [MS_WIDTH-1:0]    interval_ms;
    } request_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] linear_distance;
        logic signed [OUT_WIDTH-1:0] heading_change;
        logic signed [OUT_WIDTH-1:0] stasis_travel;
        logic signed [OUT_WIDTH-1:0] linear_speed;
        logic signed [OUT_WIDTH-1:0] turn_rate;
        logic signed [OUT_WIDTH-1:0] stasis_speed;
        logic                        interval_error;
    } result_t;

endpackage
`default_nettype wire

/* rtl/e2o_chan.sv */
`default_nettype none
module e2o_chan #(
    parameter int MAG_WIDTH   = 49,
    parameter int ROUND_SHIFT = 17
) (
    input  wire logic                                 clk,
    input  wire logic [MAG_WIDTH-1:0]                 mag,
    input  wire logic                                 neg,
    input  wire logic [e2o_pkg::MS_WIDTH-1:0]         interval_ms,
    output logic signed [e2o_pkg::OUT_WIDTH-1:0]      distance,
    output logic signed [e2o_pkg::OUT_WIDTH-1:0]      speed
);

    localparam int OW      = e2o_pkg::OUT_WIDTH;
    localparam int MSW     = e2o_pkg::MS_WIDTH;
    localparam int QW      = e2o_pkg::QUOT_WIDTH;
    localparam int NW      = e2o_pkg::NUM_WIDTH;
    localparam int STAGES  = e2o_pkg::DIV_STAGES;
    localparam int STEP    = e2o_pkg::DIV_STEP;
    // times 1000 = 1024 - 16 - 8
    localparam int MUL_SHIFT = 10;
    localparam int CLAMP_W = NW + ROUND_SHIFT - 1 - MUL_SHIFT;
    localparam int TIMES_W = CLAMP_W + MUL_SHIFT;
    localparam int EXT_W   = (MAG_WIDTH > CLAMP_W) ? MAG_WIDTH : CLAMP_W;

    typedef struct packed {
        logic [CLAMP_W-1:0] mc;
        logic [TIMES_W-1:0] t;
        logic               big;
        logic               neg;
        logic [MSW-1:0]     ms;
        logic [OW-1:0]      travel;
    } front_t;

    typedef struct packed {
        logic [MSW-1:0] rem;
        logic [QW-1:0]  work;
        logic           sat;
        logic           neg;
        logic [MSW-1:0] ms;
        logic [OW-1:0]  travel;
    } divstage_t;

    front_t        s1_reg, s1_next;
    divstage_t     div_reg  [STAGES+1];
    divstage_t     div_next [STAGES+1];
    logic [OW-1:0] distance_reg, distance_next;
    logic [OW-1:0] speed_reg, speed_next;

    always_comb
    begin
        logic [EXT_W-1:0]   m_ext;
        logic [EXT_W:0]     rsum;
        logic [EXT_W:0]     rq;
        logic [EXT_W:0]     rlim;
        logic [CLAMP_W-1:0] mc;
        logic [TIMES_W-1:0] nfull;
        logic [NW-1:0]      nq;
        logic [MSW:0]       trial;
        logic [QW:0]        qp;
        logic [QW-1:0]      qr;
        logic [QW-1:0]      slim;
        divstage_t          last;

        // distance: round half away from zero, then saturate
        m_ext = EXT_W'(mag);
        mc    = m_ext[CLAMP_W-1:0];
        rsum  = {1'b0, m_ext} + ((EXT_W+1)'(1) << (ROUND_SHIFT - 1));
        rq    = rsum >> ROUND_SHIFT;
        rlim  = (EXT_W+1)'(neg ? e2o_pkg::SAT_NEG : e2o_pkg::SAT_POS);
        if (rq > rlim)
        begin
            s1_next.travel = neg ? e2o_pkg::SAT_NEG : e2o_pkg::SAT_POS;
        end
        else if (neg)
        begin
            s1_next.travel = OW'(0) - rq[OW-1:0];
        end
        else
        begin
            s1_next.travel = rq[OW-1:0];
        end
        s1_next.mc  = mc;
        s1_next.t   = {mc, MUL_SHIFT'(0)} - TIMES_W'({mc, 4'b0});
        s1_next.big = (m_ext >> CLAMP_W) != '0;
        s1_next.neg = neg;
        s1_next.ms  = interval_ms;

        // dividend with the bits below the half-step dropped
        nfull = s1_reg.t - TIMES_W'({s1_reg.mc, 3'b0});
        nq    = nfull[TIMES_W-1:ROUND_SHIFT-1];
        div_next[0].rem    = nq[NW-2:QW];
        div_next[0].work   = nq[QW-1:0];
        div_next[0].sat    = s1_reg.big || nq[NW-1] || (nq[NW-2:QW] >= s1_reg.ms);
        div_next[0].neg    = s1_reg.neg;
        div_next[0].ms     = s1_reg.ms;
        div_next[0].travel = s1_reg.travel;

        // restoring division, STEP quotient bits per stage
        for (int s = 0; s < STAGES; s++)
        begin
            div_next[s+1] = div_reg[s];
            for (int j = 0; j < STEP; j++)
            begin
                if (s * STEP + j < QW)
                begin
                    trial = {div_next[s+1].rem, div_next[s+1].work[QW-1]};
                    div_next[s+1].work = {div_next[s+1].work[QW-2:0], 1'b0};
                    if (trial >= {1'b0, div_next[s+1].ms})
                    begin
                        trial = trial - {1'b0, div_next[s+1].ms};
                        div_next[s+1].work[0] = 1'b1;
                    end
                    div_next[s+1].rem = trial[MSW-1:0];
                end
            end
        end

        // quotient is in half steps: add one and halve to round
        last = div_reg[STAGES];
        qp   = {1'b0, last.work} + (QW+1)'(1);
        qr   = qp[QW:1];
        slim = QW'(last.neg ? e2o_pkg::SAT_NEG : e2o_pkg::SAT_POS);
        if (last.ms == '0)
        begin
            speed_next = '0;
        end
        else if (last.sat || (qr > slim))
        begin
            speed_next = last.neg ? e2o_pkg::SAT_NEG : e2o_pkg::SAT_POS;
        end
        else if (last.neg)
        begin
            speed_next = OW'(0) - qr[OW-1:0];
        end
        else
        begin
            speed_next = qr[OW-1:0];
        end
        distance_next = last.travel;
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        div_reg      <= div_next;
        distance_reg <= distance_next;
        speed_reg    <= speed_next;
    end

    assign distance = distance_reg;
    assign speed    = speed_reg;

endmodule
`default_nettype wire

/* rtl/encoder_counts_to_odometry.sv */
// Odometry from encoder counts: one request accepted in every cycle, busy stays low.
// The result strobe follows the accepting edge through the pipeline
// (5 multiply and magnitude stages, then 12 stages of round and speed divider).
// Throughput: one request per cycle, set by the fully pipelined divider stages.
// Reset (rst_n low, asynchronous): scale registers read 0 and no request is in flight.
`default_nettype none
module encoder_counts_to_odometry (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire e2o_pkg::request_t                      request,
    output logic                                        done,
    output e2o_pkg::result_t                            result,
    input  wire logic                                   cfg_write,
    input  wire e2o_pkg::cfg_index_t                    cfg_index,
    input  wire logic [e2o_pkg::SCALE_WIDTH-1:0]        cfg_data
);

    localparam int CW    = e2o_pkg::COUNT_WIDTH;
    localparam int SCW   = e2o_pkg::SCALE_WIDTH;
    localparam int MSW   = e2o_pkg::MS_WIDTH;
    localparam int OW    = e2o_pkg::OUT_WIDTH;
    localparam int PW    = CW + SCW + 1;
    localparam int SW    = PW + 1;
    localparam int MW    = PW;
    localparam int PMW   = PW - 1;
    localparam int HW    = MW + SCW;
    localparam int TOTAL = e2o_pkg::FRONT_LATENCY + e2o_pkg::CHAN_LATENCY;

    typedef struct packed {
        logic signed [PW-1:0] pl;
        logic signed [PW-1:0] pr;
        logic signed [PW-1:0] ps;
        logic [MSW-1:0]       ms;
    } prod_t;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] dif;
        logic signed [PW-1:0] ps;
        logic [MSW-1:0]       ms;
    } comb_t;

    typedef struct packed {
        logic [MW-1:0]  mag_s;
        logic           neg_s;
        logic [MW-1:0]  mag_d;
        logic           neg_d;
        logic [PMW-1:0] mag_p;
        logic           neg_p;
        logic [MSW-1:0] ms;
    } mag_t;

    typedef struct packed {
        logic [MW-1:0]    mag_s;
        logic             neg_s;
        logic [2*SCW-1:0] h_lo;
        logic [MW-1:0]    h_hi;
        logic             neg_d;
        logic [PMW-1:0]   mag_p;
        logic             neg_p;
        logic [MSW-1:0]   ms;
    } part_t;

    typedef struct packed {
        logic [MW-1:0]  mag_s;
        logic           neg_s;
        logic [HW-1:0]  mag_h;
        logic           neg_d;
        logic [PMW-1:0] mag_p;
        logic           neg_p;
        logic [MSW-1:0] ms;
    } chan_in_t;

    logic [SCW-1:0] left_scale_reg, left_scale_next;
    logic [SCW-1:0] right_scale_reg, right_scale_next;
    logic [SCW-1:0] stasis_scale_reg, stasis_scale_next;
    logic [SCW-1:0] inverse_wheel_base_reg, inverse_wheel_base_next;

    prod_t    p1_reg, p1_next;
    comb_t    p2_reg, p2_next;
    mag_t     p3_reg, p3_next;
    part_t    p4_reg, p4_next;
    chan_in_t p5_reg, p5_next;

    logic valid_reg [TOTAL];
    logic valid_next [TOTAL];
    logic err_reg [TOTAL];
    logic err_next [TOTAL];

    logic signed [OW-1:0] lin_dist, lin_speed;
    logic signed [OW-1:0] head_dist, head_rate;
    logic signed [OW-1:0] stas_dist, stas_speed;

    assign busy = 1'b0;

    always_comb
    begin
        left_scale_next         = left_scale_reg;
        right_scale_next        = right_scale_reg;
        stasis_scale_next       = stasis_scale_reg;
        inverse_wheel_base_next = inverse_wheel_base_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                e2o_pkg::REG_LEFT_SCALE:         left_scale_next         = cfg_data;
                e2o_pkg::REG_RIGHT_SCALE:        right_scale_next        = cfg_data;
                e2o_pkg::REG_STASIS_SCALE:       stasis_scale_next       = cfg_data;
                e2o_pkg::REG_INVERSE_WHEEL_BASE: inverse_wheel_base_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        logic [SW-1:0] sum_abs;
        logic [SW-1:0] dif_abs;
        logic [PW-1:0] ps_abs;

        p1_next.pl = $signed(request.left_ticks) * $signed({1'b0, left_scale_reg});
        p1_next.pr = $signed(request.right_ticks) * $signed({1'b0, right_scale_reg});
        p1_next.ps = $signed(request.stasis_ticks) * $signed({1'b0, stasis_scale_reg});
        p1_next.ms = request.interval_ms;

        p2_next.sum = SW'(p1_reg.pl) + SW'(p1_reg.pr);
        p2_next.dif = SW'(p1_reg.pr) - SW'(p1_reg.pl);
        p2_next.ps  = p1_reg.ps;
        p2_next.ms  = p1_reg.ms;

        sum_abs = p2_reg.sum[SW-1] ? (-p2_reg.sum) : p2_reg.sum;
        dif_abs = p2_reg.dif[SW-1] ? (-p2_reg.dif) : p2_reg.dif;
        ps_abs  = p2_reg.ps[PW-1] ? (-p2_reg.ps) : p2_reg.ps;
        p3_next.mag_s = sum_abs[MW-1:0];
        p3_next.neg_s = p2_reg.sum[SW-1];
        p3_next.mag_d = dif_abs[MW-1:0];
        p3_next.neg_d = p2_reg.dif[SW-1];
        p3_next.mag_p = ps_abs[PMW-1:0];
        p3_next.neg_p = p2_reg.ps[PW-1];
        p3_next.ms    = p2_reg.ms;

        // heading product split into low and high partial products
        p4_next.mag_s = p3_reg.mag_s;
        p4_next.neg_s = p3_reg.neg_s;
        p4_next.h_lo  = p3_reg.mag_d[SCW-1:0] * inverse_wheel_base_reg;
        p4_next.h_hi  = p3_reg.mag_d[MW-1:SCW] * inverse_wheel_base_reg;
        p4_next.neg_d = p3_reg.neg_d;
        p4_next.mag_p = p3_reg.mag_p;
        p4_next.neg_p = p3_reg.neg_p;
        p4_next.ms    = p3_reg.ms;

        p5_next.mag_s = p4_reg.mag_s;
        p5_next.neg_s = p4_reg.neg_s;
        p5_next.mag_h = HW'({p4_reg.h_hi, SCW'(0)}) + HW'(p4_reg.h_lo);
        p5_next.neg_d = p4_reg.neg_d;
        p5_next.mag_p = p4_reg.mag_p;
        p5_next.neg_p = p4_reg.neg_p;
        p5_next.ms    = p4_reg.ms;
    end

    always_comb
    begin
        valid_next[0] = start && !busy;
        err_next[0]   = request.interval_ms == '0;
        for (int i = 1; i < TOTAL; i++)
        begin
            valid_next[i] = valid_reg[i-1];
            err_next[i]   = err_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_scale_reg         <= '0;
            right_scale_reg        <= '0;
            stasis_scale_reg       <= '0;
            inverse_wheel_base_reg <= '0;
            for (int i = 0; i < TOTAL; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            left_scale_reg         <= left_scale_next;
            right_scale_reg        <= right_scale_next;
            stasis_scale_reg       <= stasis_scale_next;
            inverse_wheel_base_reg <= inverse_wheel_base_next;
            valid_reg              <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        p3_reg  <= p3_next;
        p4_reg  <= p4_next;
        p5_reg  <= p5_next;
        err_reg <= err_next;
    end

    e2o_chan #(
        .MAG_WIDTH   (MW),
        .ROUND_SHIFT (e2o_pkg::LINEAR_SHIFT)
    ) u_linear (
        .clk         (clk),
        .mag         (p5_reg.mag_s),
        .neg         (p5_reg.neg_s),
        .interval_ms (p5_reg.ms),
        .distance    (lin_dist),
        .speed       (lin_speed)
    );

    e2o_chan #(
        .MAG_WIDTH   (HW),
        .ROUND_SHIFT (e2o_pkg::HEADING_SHIFT)
    ) u_heading (
        .clk         (clk),
        .mag         (p5_reg.mag_h),
        .neg         (p5_reg.neg_d),
        .interval_ms (p5_reg.ms),
        .distance    (head_dist),
        .speed       (head_rate)
    );

    e2o_chan #(
        .MAG_WIDTH   (PMW),
        .ROUND_SHIFT (e2o_pkg::STASIS_SHIFT)
    ) u_stasis (
        .clk         (clk),
        .mag         (p5_reg.mag_p),
        .neg         (p5_reg.neg_p),
        .interval_ms (p5_reg.ms),
        .distance    (stas_dist),
        .speed       (stas_speed)
    );

    always_comb
    begin
        result.linear_distance = lin_dist;
        result.heading_change  = head_dist;
        result.stasis_travel   = stas_dist;
        result.linear_speed    = lin_speed;
        result.turn_rate       = head_rate;
        result.stasis_speed    = stas_speed;
        result.interval_error  = err_reg[TOTAL-1];
    end

    assign done = valid_reg[TOTAL-1];

endmodule
`default_nettype wire
